>>> rtl/pcvp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the point-cloud view projection block.
// No dependencies; every other file of the block imports this package.
package pcvp_pkg;

  localparam int COEF_W      = 16;   // one packed matrix coefficient or offset
  localparam int CFG_W       = 64;   // widest configuration register
  localparam int CFG_IDX_W   = 3;
  localparam int PIX_W       = 16;
  localparam int Q_SH        = 16;   // perspective divisor is c scaled by 2^16
  localparam int DIV_STAGES  = PIX_W; // one quotient bit per stage
  localparam int DIV_REM_W   = 48;   // remainder stays below c * 2^16 < 2^47
  localparam int SQRT_STAGES = 32;   // one root bit per stage
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = 2;
  localparam int FIFO_CW     = 3;

  localparam logic MODE_BIRD  = 1'b0;
  localparam logic MODE_PERSP = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 3'd0,
    CFG_SEL    = 3'd1,
    CFG_ROW_A  = 3'd2,
    CFG_ROW_B  = 3'd3,
    CFG_ROW_C  = 3'd4,
    CFG_SCALE  = 3'd5,
    CFG_WIDTH  = 3'd6,
    CFG_HEIGHT = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    VSEL_X     = 3'd0,
    VSEL_Y     = 3'd1,
    VSEL_Z     = 3'd2,
    VSEL_DIST  = 3'd3,
    VSEL_INTEN = 3'd4
  } vsel_t;

  // Front to back: view coordinates and the value side data of one point.
  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic [63:0]        dsq;
    logic signed [31:0] vdir;
    logic               is_dist;
  } view_item_t;

  // Side data that rides along the divider stages.
  typedef struct packed {
    logic               valid;
    logic               keep;
    logic [PIX_W-1:0]   u_bird;
    logic [PIX_W-1:0]   v_bird;
    logic signed [31:0] depth;
    logic signed [31:0] vdir;
    logic               is_dist;
  } side_t;

  // Finished projection waiting for the distance root.
  typedef struct packed {
    logic               valid;
    logic [PIX_W-1:0]   u;
    logic [PIX_W-1:0]   v;
    logic signed [31:0] depth;
    logic signed [31:0] vdir;
    logic               is_dist;
  } fin_t;

endpackage

>>> rtl/point_cloud_view_projection_top.sv
`timescale 1ns / 1ps
// Top level of the point-cloud view projection block: configuration registers
// and the front / queue / back pipeline. Depends on pcvp_pkg and all pcvp_* modules.
//
// Projects one Q16.16 point per clock onto a 2D canvas through a configured
// 3x4 view matrix, either as a bird's-eye orthographic view or as a pinhole
// perspective view. A point is taken at a rising edge with start high and
// busy low. Non-finite points, points at or behind the camera (perspective)
// and points landing off the canvas give no result; every other point gives
// one result, in input order, shown for exactly one cycle with out_strobe
// high. The receiver cannot stall, so nothing ever backs up: busy stays low
// in normal use and the block sustains one point per cycle. A result passes
// through 4 front stages, one queue slot, then the back pipeline, whose
// length is set by the 32-stage distance root; the 16-stage pixel dividers
// run alongside it. Write configuration only while no point is in flight.
module point_cloud_view_projection_top #(
  parameter int POINT_FRAC_BITS = 16,
  parameter int COEF_FRAC_BITS  = 14
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [31:0]                  in_point_x,
  input  logic signed [31:0]                  in_point_y,
  input  logic signed [31:0]                  in_point_z,
  input  logic signed [31:0]                  in_point_intensity,
  input  logic                                in_point_finite,
  output logic                                out_strobe,
  output logic [pcvp_pkg::PIX_W-1:0]          out_pixel_u,
  output logic [pcvp_pkg::PIX_W-1:0]          out_pixel_v,
  output logic signed [31:0]                  out_point_depth,
  output logic signed [31:0]                  out_point_value,
  input  logic                                cfg_we,
  input  logic [pcvp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pcvp_pkg::CFG_W-1:0]          cfg_wdata
);
  import pcvp_pkg::*;

  // configuration registers
  logic             mode_r;
  logic [2:0]       sel_r;
  logic [63:0]      row_a_r, row_b_r, row_c_r;
  logic [31:0]      scale_r;
  logic [PIX_W-1:0] width_r, height_r;

  // front to queue, queue to back
  logic       push, full, empty;
  view_item_t push_item, pop_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_BIRD;
      sel_r    <= VSEL_X;
      row_a_r  <= '0;
      row_b_r  <= '0;
      row_c_r  <= '0;
      scale_r  <= 32'd65536;   // 1.0 in Q16.16
      width_r  <= 16'd640;
      height_r <= 16'd480;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MODE:   mode_r   <= cfg_wdata[0];
        CFG_SEL:    sel_r    <= cfg_wdata[2:0];
        CFG_ROW_A:  row_a_r  <= cfg_wdata;
        CFG_ROW_B:  row_b_r  <= cfg_wdata;
        CFG_ROW_C:  row_c_r  <= cfg_wdata;
        CFG_SCALE:  scale_r  <= cfg_wdata[31:0];
        CFG_WIDTH:  width_r  <= cfg_wdata[PIX_W-1:0];
        CFG_HEIGHT: height_r <= cfg_wdata[PIX_W-1:0];
      endcase
    end
  end

  // matrix multiply and value select; a transfer is dropped here if not finite
  pcvp_front #(
    .POINT_FRAC_BITS (POINT_FRAC_BITS),
    .COEF_FRAC_BITS  (COEF_FRAC_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .x_i            (in_point_x),
    .y_i            (in_point_y),
    .z_i            (in_point_z),
    .inten_i        (in_point_intensity),
    .finite_i       (in_point_finite),
    .row_a_i        (row_a_r),
    .row_b_i        (row_b_r),
    .row_c_i        (row_c_r),
    .value_select_i (sel_r),
    .full_i         (full),
    .busy_o         (busy),
    .push_o         (push),
    .push_item_o    (push_item)
  );

  // back never stalls, so it drains the queue whenever it holds an item
  pcvp_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (!empty),
    .pop_item_o  (pop_item),
    .empty_o     (empty)
  );

  pcvp_back #(
    .POINT_FRAC_BITS (POINT_FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid_i    (!empty),
    .item_i          (pop_item),
    .mode_i          (mode_r),
    .scale_i         (scale_r),
    .width_i         (width_r),
    .height_i        (height_r),
    .out_strobe      (out_strobe),
    .out_pixel_u     (out_pixel_u),
    .out_pixel_v     (out_pixel_v),
    .out_point_depth (out_point_depth),
    .out_point_value (out_point_value)
  );

endmodule

>>> rtl/pcvp_fifo.sv
`timescale 1ns / 1ps
// Short flop-based queue between front and back of the projection block.
// Depends on pcvp_pkg (view_item_t, depth constants).
module pcvp_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_i,
  input  pcvp_pkg::view_item_t push_item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output pcvp_pkg::view_item_t pop_item_o,
  output logic                 empty_o
);
  import pcvp_pkg::*;

  view_item_t         mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0] count_r, count_nxt;
  logic               do_push, do_pop;

  assign full_o     = (count_r == FIFO_CW'(FIFO_DEPTH));
  assign empty_o    = (count_r == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_item_o = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item_i;
    end
  end

endmodule

>>> rtl/pcvp_front.sv
`timescale 1ns / 1ps
// Front of the projection block: takes points, drops non-finite ones and
// maps them through the 3x4 view matrix. Depends on pcvp_pkg.
module pcvp_front #(
  parameter int POINT_FRAC_BITS = 16,
  parameter int COEF_FRAC_BITS  = 14
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [31:0]   x_i,
  input  logic signed [31:0]   y_i,
  input  logic signed [31:0]   z_i,
  input  logic signed [31:0]   inten_i,
  input  logic                 finite_i,
  input  logic [63:0]          row_a_i,
  input  logic [63:0]          row_b_i,
  input  logic [63:0]          row_c_i,
  input  logic [2:0]           value_select_i,
  input  logic                 full_i,
  output logic                 busy_o,
  output logic                 push_o,
  output pcvp_pkg::view_item_t push_item_o
);
  import pcvp_pkg::*;

  localparam int OFS_SH = COEF_FRAC_BITS + POINT_FRAC_BITS - 7;
  localparam int OFS_W  = COEF_W + OFS_SH;
  localparam int PROD_W = COEF_W + 32;
  localparam int ACC_W  = ((PROD_W > OFS_W) ? PROD_W : OFS_W) + 2;
  localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

  function automatic logic signed [31:0] sat_round(input logic signed [ACC_W-1:0] acc);
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] rnd;
    mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    rnd = (mag + RND_HALF) >> COEF_FRAC_BITS;
    if (acc[ACC_W-1]) begin
      sat_round = (rnd >= ACC_W'(33'h0_8000_0000)) ? 32'sh8000_0000 : 32'(0 - rnd[31:0]);
    end else begin
      sat_round = (rnd > ACC_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : rnd[31:0];
    end
  endfunction

  logic en;

  // stage 0: captured point
  logic               f0_valid_r;
  logic signed [31:0] x_r, y_r, z_r, inten_r;

  // stage 1: products
  logic                     f1_valid_r;
  logic signed [PROD_W-1:0] prod_r   [3][3];
  logic signed [PROD_W-1:0] prod_nxt [3][3];
  logic signed [COEF_W-1:0] ofs_r    [3];
  logic [63:0]              sq_r     [3];
  logic signed [63:0]       sq_nxt   [3];
  logic signed [31:0]       coord    [3];
  logic [63:0]              rows     [3];
  logic signed [31:0]       f1_vdir_r, vdir_nxt;
  logic                     f1_dist_r;

  // stage 2: sums
  logic                    f2_valid_r;
  logic signed [ACC_W-1:0] acc_r   [3];
  logic signed [ACC_W-1:0] acc_nxt [3];
  logic [63:0]             f2_dsq_r;
  logic signed [31:0]      f2_vdir_r;
  logic                    f2_dist_r;

  // stage 3: rounded view coordinates
  logic       f3_valid_r;
  view_item_t item_r, item_nxt;

  assign en          = !(f3_valid_r && full_i);
  assign busy_o      = !en;
  assign push_o      = f3_valid_r;
  assign push_item_o = item_r;

  always_comb begin
    coord[0] = x_r;
    coord[1] = y_r;
    coord[2] = z_r;
    rows[0]  = row_a_i;
    rows[1]  = row_b_i;
    rows[2]  = row_c_i;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        prod_nxt[r][k] = $signed(rows[r][COEF_W*k +: COEF_W]) * coord[k];
      end
    end
    for (int k = 0; k < 3; k++) begin
      sq_nxt[k] = coord[k] * coord[k];
    end
    case (vsel_t'(value_select_i))
      VSEL_X:     vdir_nxt = x_r;
      VSEL_Y:     vdir_nxt = y_r;
      VSEL_Z:     vdir_nxt = z_r;
      VSEL_INTEN: vdir_nxt = inten_r;
      default:    vdir_nxt = '0;
    endcase
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc_nxt[r] = ACC_W'(prod_r[r][0]) + ACC_W'(prod_r[r][1]) + ACC_W'(prod_r[r][2])
                 + (ACC_W'(ofs_r[r]) <<< OFS_SH);
    end
    item_nxt.a       = sat_round(acc_r[0]);
    item_nxt.b       = sat_round(acc_r[1]);
    item_nxt.c       = sat_round(acc_r[2]);
    item_nxt.dsq     = f2_dsq_r;
    item_nxt.vdir    = f2_vdir_r;
    item_nxt.is_dist = f2_dist_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_valid_r <= 1'b0;
      f1_valid_r <= 1'b0;
      f2_valid_r <= 1'b0;
      f3_valid_r <= 1'b0;
    end else if (en) begin
      f0_valid_r <= start && finite_i;
      f1_valid_r <= f0_valid_r;
      f2_valid_r <= f1_valid_r;
      f3_valid_r <= f2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r     <= x_i;
      y_r     <= y_i;
      z_r     <= z_i;
      inten_r <= inten_i;
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod_r[r][k] <= prod_nxt[r][k];
        end
        ofs_r[r] <= $signed(rows[r][CFG_W-1 -: COEF_W]);
        acc_r[r] <= acc_nxt[r];
      end
      for (int k = 0; k < 3; k++) begin
        sq_r[k] <= $unsigned(sq_nxt[k]);
      end
      f1_vdir_r <= vdir_nxt;
      f1_dist_r <= (vsel_t'(value_select_i) == VSEL_DIST);
      f2_dsq_r  <= sq_r[0] + sq_r[1] + sq_r[2];
      f2_vdir_r <= f1_vdir_r;
      f2_dist_r <= f1_dist_r;
      item_r    <= item_nxt;
    end
  end

endmodule

>>> rtl/pcvp_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage.
// Depends on pcvp_pkg (stage count and widths).
module pcvp_div (
  input  logic                           clk,
  input  logic [pcvp_pkg::DIV_REM_W-1:0] rem_i,
  input  logic [31:0]                    den_i,
  output logic [pcvp_pkg::PIX_W-1:0]     quo_o
);
  import pcvp_pkg::*;

  logic [DIV_REM_W-1:0] rem_r   [DIV_STAGES];
  logic [DIV_REM_W-1:0] rem_src [DIV_STAGES];
  logic [DIV_REM_W-1:0] rem_nxt [DIV_STAGES];
  logic [31:0]          den_r   [DIV_STAGES];
  logic [31:0]          den_src [DIV_STAGES];
  logic [PIX_W-1:0]     quo_r   [DIV_STAGES];
  logic [PIX_W-1:0]     quo_src [DIV_STAGES];
  logic [PIX_W-1:0]     quo_nxt [DIV_STAGES];
  logic [DIV_REM_W-1:0] trial;

  assign quo_o = quo_r[DIV_STAGES-1];

  always_comb begin
    rem_src[0] = rem_i;
    den_src[0] = den_i;
    quo_src[0] = '0;
    for (int k = 1; k < DIV_STAGES; k++) begin
      rem_src[k] = rem_r[k-1];
      den_src[k] = den_r[k-1];
      quo_src[k] = quo_r[k-1];
    end
    trial = '0;
    for (int k = 0; k < DIV_STAGES; k++) begin
      trial = DIV_REM_W'(den_src[k]) << (DIV_STAGES - 1 - k);
      if (rem_src[k] >= trial) begin
        rem_nxt[k] = rem_src[k] - trial;
        quo_nxt[k] = quo_src[k] | (PIX_W'(1) << (DIV_STAGES - 1 - k));
      end else begin
        rem_nxt[k] = rem_src[k];
        quo_nxt[k] = quo_src[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      rem_r[k] <= rem_nxt[k];
      den_r[k] <= den_src[k];
      quo_r[k] <= quo_nxt[k];
    end
  end

endmodule

>>> rtl/pcvp_sqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, rounded to nearest and saturated to 31 bits.
// Depends on pcvp_pkg (stage count).
module pcvp_sqrt (
  input  logic        clk,
  input  logic [63:0] dsq_i,
  output logic [31:0] root_o
);
  import pcvp_pkg::*;

  logic [63:0] rem_r   [SQRT_STAGES];
  logic [63:0] rem_src [SQRT_STAGES];
  logic [63:0] rem_nxt [SQRT_STAGES];
  logic [64:0] res_r   [SQRT_STAGES];
  logic [64:0] res_src [SQRT_STAGES];
  logic [64:0] res_nxt [SQRT_STAGES];
  logic [64:0] bit_k, trial;
  logic [32:0] rounded;
  logic [31:0] root_r;

  assign root_o = root_r;

  always_comb begin
    rem_src[0] = dsq_i;
    res_src[0] = '0;
    for (int k = 1; k < SQRT_STAGES; k++) begin
      rem_src[k] = rem_r[k-1];
      res_src[k] = res_r[k-1];
    end
    bit_k = '0;
    trial = '0;
    for (int k = 0; k < SQRT_STAGES; k++) begin
      bit_k = 65'd1 << (2 * (SQRT_STAGES - 1 - k));
      trial = res_src[k] + bit_k;
      if ({1'b0, rem_src[k]} >= trial) begin
        rem_nxt[k] = rem_src[k] - trial[63:0];
        res_nxt[k] = (res_src[k] >> 1) + bit_k;
      end else begin
        rem_nxt[k] = rem_src[k];
        res_nxt[k] = res_src[k] >> 1;
      end
    end
    // round up when the remainder passes the root
    rounded = res_r[SQRT_STAGES-1][32:0]
            + 33'({1'b0, rem_r[SQRT_STAGES-1]} > res_r[SQRT_STAGES-1]);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SQRT_STAGES; k++) begin
      rem_r[k] <= rem_nxt[k];
      res_r[k] <= res_nxt[k];
    end
    root_r <= (rounded > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : rounded[31:0];
  end

endmodule

>>> rtl/pcvp_back.sv
`timescale 1ns / 1ps
// Back of the projection block: canvas mapping, pipelined divides, distance
// root and result register. Depends on pcvp_pkg, pcvp_div and pcvp_sqrt.
module pcvp_back #(
  parameter int POINT_FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         item_valid_i,
  input  pcvp_pkg::view_item_t         item_i,
  input  logic                         mode_i,
  input  logic [31:0]                  scale_i,
  input  logic [pcvp_pkg::PIX_W-1:0]   width_i,
  input  logic [pcvp_pkg::PIX_W-1:0]   height_i,
  output logic                         out_strobe,
  output logic [pcvp_pkg::PIX_W-1:0]   out_pixel_u,
  output logic [pcvp_pkg::PIX_W-1:0]   out_pixel_v,
  output logic signed [31:0]           out_point_depth,
  output logic signed [31:0]           out_point_value
);
  import pcvp_pkg::*;

  localparam int PA_W    = 65;
  localparam int WC_W    = 50;
  localparam int T_W     = 68;
  localparam int BIRD_SH = POINT_FRAC_BITS + 16;
  // length of the delay line that holds finished pixel results until the
  // registered distance root is ready
  localparam int ALIGN   = SQRT_STAGES + 2 - (DIV_STAGES + 4);
  // largest c dropped in perspective view (c * 1e6 must exceed 2^frac)
  localparam logic [31:0] C_MIN = 32'((64'd1 << POINT_FRAC_BITS) / 64'd1000000);

  logic [PIX_W:0] w_p1, h_p1;

  // B0: products
  logic                   b0_valid_r;
  logic signed [PA_W-1:0] pa_r, pb_r, pa_nxt, pb_nxt;
  logic signed [WC_W-1:0] wc_r, hc_r, wc_nxt, hc_nxt;
  logic signed [31:0]     b0_c_r, b0_vdir_r;
  logic                   b0_dist_r;

  // B1: rounding numerators
  logic                  b1_valid_r;
  logic signed [T_W-1:0] tu_r, tv_r, tu_nxt, tv_nxt;
  logic signed [31:0]    b1_c_r, b1_vdir_r;
  logic                  b1_dist_r;

  // B2: range checks, divider operands
  side_t                 b2_side_r, side_nxt;
  logic [DIV_REM_W-1:0]  rem_u_r, rem_v_r;
  logic [31:0]           den_r;
  logic [T_W-1:0]        nu, nv, lim, ub, vb;
  logic                  keep_p, keep_b;

  side_t            side_line_r [DIV_STAGES];
  fin_t             fin_line_r  [ALIGN];
  fin_t             fin_nxt;
  side_t            side_q;
  logic [PIX_W-1:0] qu, qv;
  logic [31:0]      root;

  assign w_p1 = {1'b0, width_i} + 1'b1;
  assign h_p1 = {1'b0, height_i} + 1'b1;

  assign pa_nxt = $signed({1'b0, scale_i}) * item_i.a;
  assign pb_nxt = $signed({1'b0, scale_i}) * item_i.b;
  assign wc_nxt = $signed({1'b0, w_p1}) * item_i.c;
  assign hc_nxt = $signed({1'b0, h_p1}) * item_i.c;

  always_comb begin
    if (mode_i == MODE_PERSP) begin
      tu_nxt = T_W'(pa_r) + (T_W'(wc_r) <<< (Q_SH - 1));
      tv_nxt = -T_W'(pb_r) + (T_W'(hc_r) <<< (Q_SH - 1));
    end else begin
      tu_nxt = -T_W'(pb_r) + $signed(T_W'(w_p1) << (BIRD_SH - 1));
      tv_nxt = -T_W'(pa_r) + $signed(T_W'(h_p1) << (BIRD_SH - 1));
    end
  end

  always_comb begin
    nu  = $unsigned(tu_r >>> Q_SH);
    nv  = $unsigned(tv_r >>> Q_SH);
    lim = T_W'({b1_c_r, {Q_SH{1'b0}}});
    ub  = $unsigned(tu_r >>> BIRD_SH);
    vb  = $unsigned(tv_r >>> BIRD_SH);
    keep_p = ($signed(b1_c_r) > $signed(C_MIN)) && (tu_r > 0) && (tv_r > 0)
          && (nu < lim) && (nv < lim);
    keep_b = (tu_r > 0) && (tv_r > 0) && (ub < T_W'(width_i)) && (vb < T_W'(height_i));
    side_nxt.valid   = b1_valid_r;
    side_nxt.keep    = (mode_i == MODE_PERSP) ? keep_p : keep_b;
    side_nxt.u_bird  = ub[PIX_W-1:0];
    side_nxt.v_bird  = vb[PIX_W-1:0];
    if (mode_i == MODE_PERSP) begin
      side_nxt.depth = b1_c_r;
    end else begin
      side_nxt.depth = (b1_c_r == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -b1_c_r;
    end
    side_nxt.vdir    = b1_vdir_r;
    side_nxt.is_dist = b1_dist_r;
  end

  always_ff @(posedge clk) begin
    pa_r      <= pa_nxt;
    pb_r      <= pb_nxt;
    wc_r      <= wc_nxt;
    hc_r      <= hc_nxt;
    b0_c_r    <= item_i.c;
    b0_vdir_r <= item_i.vdir;
    b0_dist_r <= item_i.is_dist;
    tu_r      <= tu_nxt;
    tv_r      <= tv_nxt;
    b1_c_r    <= b0_c_r;
    b1_vdir_r <= b0_vdir_r;
    b1_dist_r <= b0_dist_r;
    rem_u_r   <= nu[DIV_REM_W-1:0];
    rem_v_r   <= nv[DIV_REM_W-1:0];
    den_r     <= b1_c_r;
  end

  pcvp_div u_div_u (.clk(clk), .rem_i(rem_u_r), .den_i(den_r), .quo_o(qu));
  pcvp_div u_div_v (.clk(clk), .rem_i(rem_v_r), .den_i(den_r), .quo_o(qv));
  pcvp_sqrt u_sqrt (.clk(clk), .dsq_i(item_i.dsq), .root_o(root));

  assign side_q = side_line_r[DIV_STAGES-1];

  always_comb begin
    fin_nxt.valid = side_q.valid && side_q.keep;
    if (mode_i == MODE_PERSP) begin
      fin_nxt.valid = fin_nxt.valid && (qu < width_i) && (qv < height_i);
      fin_nxt.u     = qu;
      fin_nxt.v     = qv;
    end else begin
      fin_nxt.u = side_q.u_bird;
      fin_nxt.v = side_q.v_bird;
    end
    fin_nxt.depth   = side_q.depth;
    fin_nxt.vdir    = side_q.vdir;
    fin_nxt.is_dist = side_q.is_dist;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_valid_r <= 1'b0;
      b1_valid_r <= 1'b0;
      b2_side_r  <= '0;
      for (int k = 0; k < DIV_STAGES; k++) begin
        side_line_r[k] <= '0;
      end
      for (int k = 0; k < ALIGN; k++) begin
        fin_line_r[k] <= '0;
      end
      out_strobe <= 1'b0;
    end else begin
      b0_valid_r     <= item_valid_i;
      b1_valid_r     <= b0_valid_r;
      b2_side_r      <= side_nxt;
      side_line_r[0] <= b2_side_r;
      for (int k = 1; k < DIV_STAGES; k++) begin
        side_line_r[k] <= side_line_r[k-1];
      end
      fin_line_r[0] <= fin_nxt;
      for (int k = 1; k < ALIGN; k++) begin
        fin_line_r[k] <= fin_line_r[k-1];
      end
      out_strobe <= fin_line_r[ALIGN-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    out_pixel_u     <= fin_line_r[ALIGN-1].u;
    out_pixel_v     <= fin_line_r[ALIGN-1].v;
    out_point_depth <= fin_line_r[ALIGN-1].depth;
    out_point_value <= fin_line_r[ALIGN-1].is_dist ? $signed(root) : fin_line_r[ALIGN-1].vdir;
  end

endmodule
